[rtl/core/lde_pkg.sv]
// Shared types and constants for the linked deque engine.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package lde_pkg;

  // Store geometry
  localparam int unsigned NODE_COUNT = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned SLOT_W     = $clog2(NODE_COUNT + 1);
  localparam int unsigned IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Port field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  // Queue depths between the parts
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_REMOVE     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_BAD   = 2'd3
  } status_e;

  // Decoded operation kind
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_REMOVE
  } op_e;

  typedef enum logic {
    BE_ISSUE,
    BE_LINK
  } be_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [WORD_W-1:0]   item_data;
    logic [HANDLE_W-1:0] node_handle;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   out_data;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEN_W-1:0]    out_length;
  } out_item_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] data;
    logic [SLOT_W-1:0]     handle;
    logic                  handle_in_range;
  } lde_op_t;

  // Store index of a data slot (slots start at 1, the sentinel is 0)
  function automatic logic [IDX_W-1:0] slot_idx(logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] tmp;
    tmp = slot - SLOT_W'(1);
    return IDX_W'(tmp);
  endfunction

endpackage

[rtl/core/linked_deque_engine_core.sv]
// Channel   Handshake      Payload
// command   push / full    in_item_i  (cmd, item_data, node_handle)
// result    pop / empty    res_o      (status, out_data, out_handle, out_length)
//
// A push, pop or remove passes through two back-part states: BE_ISSUE claims or reads
// the node's links in the link store, BE_LINK writes the neighbor's link back.
// A failed or unknown command finishes in BE_ISSUE. Commands queue in the front
// while the back works; a full result queue stalls the back, and full rises
// once the two-entry front queue has filled behind it.
// Reset empties the list at once; no clearing pass over the stores.
// Top level of the linked deque engine; depends on lde_pkg, lde_front,
// lde_back and lde_out_fifo.
`timescale 1ns / 1ps

module linked_deque_engine_core import lde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t res_o
);

  logic      op_valid, op_take;
  lde_op_t   op;
  logic      res_valid, res_space;
  out_item_t res_item;

  lde_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_take_i  (op_take),
    .op_o       (op)
  );

  lde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_take_o   (op_take),
    .op_i        (op),
    .res_space_i (res_space),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  lde_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_item_i  (res_item),
    .space_o    (res_space),
    .empty_o    (empty),
    .pop_i      (pop),
    .rd_item_o  (res_o)
  );

  // The back never hands over a result the queue cannot hold
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |-> res_space)
    else $error("result produced with no room in result queue");

  // A failed command reports no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status != STAT_OK) |-> (res_o.out_handle == '0))
    else $error("failed command reports a slot");

  // The list never grows past the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(res_o.out_length) <= NODE_COUNT))
    else $error("list length exceeds node count");

  // Only pops return a word; a result beat with data names a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.out_data != '0) |-> (res_o.out_handle != '0))
    else $error("data returned without a freed slot");

endmodule

[rtl/core/lde_front.sv]
// Front part: accepts commands, decodes them and holds them in a short queue.
// Depends on lde_pkg.
`timescale 1ns / 1ps

module lde_front import lde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t in_item_i,
  output logic     op_valid_o,
  input  logic     op_take_i,
  output lde_op_t  op_o
);

  lde_op_t              fq_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 wr_en, rd_en;
  lde_op_t              dec_op;

  // Decode the command and range-check the handle
  always_comb begin
    dec_op.data            = DATA_WIDTH'(in_item_i.item_data);
    dec_op.handle          = SLOT_W'(in_item_i.node_handle);
    dec_op.handle_in_range = (in_item_i.node_handle != '0) &&
                             (32'(in_item_i.node_handle) <= NODE_COUNT);
    case (in_item_i.cmd)
      CMD_PUSH_FRONT: dec_op.op = OP_PUSH_FRONT;
      CMD_PUSH_REAR:  dec_op.op = OP_PUSH_REAR;
      CMD_POP_FRONT:  dec_op.op = OP_POP_FRONT;
      CMD_POP_REAR:   dec_op.op = OP_POP_REAR;
      CMD_REMOVE:     dec_op.op = OP_REMOVE;
      default:        dec_op.op = OP_NONE;
    endcase
  end

  // Queue bookkeeping
  assign full_o     = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = fq_mem[rd_ptr_q];
  assign wr_en      = push_i && !full_o;
  assign rd_en      = op_take_i && op_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (32'(wr_ptr_q) == FQ_DEPTH - 1) ? '0 : wr_ptr_q + FQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (32'(rd_ptr_q) == FQ_DEPTH - 1) ? '0 : rd_ptr_q + FQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + FQ_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - FQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the decoded beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fq_mem[wr_ptr_q] <= dec_op;
    end
  end

endmodule

[rtl/core/lde_back.sv]
// Back part: executes list commands against the link and word stores.
// Depends on lde_pkg.
`timescale 1ns / 1ps

module lde_back import lde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  output logic      op_take_o,
  input  lde_op_t   op_i,
  input  logic      res_space_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  // Node stores, indexed by slot minus one
  logic [SLOT_W-1:0]     next_mem [NODE_COUNT];
  logic [SLOT_W-1:0]     prev_mem [NODE_COUNT];
  logic [DATA_WIDTH-1:0] word_mem [NODE_COUNT];

  be_state_e             state_q, state_d;
  logic [SLOT_W-1:0]     head_q, head_d;
  logic [SLOT_W-1:0]     tail_q, tail_d;
  logic [SLOT_W-1:0]     len_q, len_d;
  logic [NODE_COUNT-1:0] in_use_q, in_use_d;
  op_e                   fix_kind_q, fix_kind_d;
  logic [SLOT_W-1:0]     fix_slot_q, fix_slot_d;
  logic [SLOT_W-1:0]     fix_nbr_q, fix_nbr_d;
  logic [SLOT_W-1:0]     rd_next_q, rd_prev_q;
  logic [DATA_WIDTH-1:0] rd_word_q;

  logic                  nx_we, pv_we, wd_we, rd_en;
  logic [IDX_W-1:0]      nx_waddr, pv_waddr, wd_waddr, rd_addr;
  logic [SLOT_W-1:0]     nx_wdata, pv_wdata;

  logic                  go, need_link;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     unl_slot;
  logic                  remove_ok;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
    free_slot = SLOT_W'(free_idx) + SLOT_W'(1);
  end

  // Classify the command at the head of the queue
  always_comb begin
    go        = (state_q == BE_ISSUE) && op_valid_i && res_space_i;
    remove_ok = op_i.handle_in_range && in_use_q[slot_idx(op_i.handle)];
    unl_slot  = op_i.handle;
    need_link = 1'b0;
    case (op_i.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: need_link = free_found;
      OP_POP_FRONT: begin
        unl_slot  = head_q;
        need_link = (len_q != '0);
      end
      OP_POP_REAR: begin
        unl_slot  = tail_q;
        need_link = (len_q != '0);
      end
      OP_REMOVE: need_link = remove_ok;
      default:   need_link = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_ISSUE: if (go && need_link) state_d = BE_LINK;
      BE_LINK:  state_d = BE_ISSUE;
      default:  state_d = BE_ISSUE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    len_d      = len_q;
    in_use_d   = in_use_q;
    fix_kind_d = fix_kind_q;
    fix_slot_d = fix_slot_q;
    fix_nbr_d  = fix_nbr_q;
    nx_we      = 1'b0;
    nx_waddr   = '0;
    nx_wdata   = '0;
    pv_we      = 1'b0;
    pv_waddr   = '0;
    pv_wdata   = '0;
    wd_we      = 1'b0;
    wd_waddr   = free_idx;
    rd_en      = 1'b0;
    rd_addr    = slot_idx(unl_slot);
    op_take_o  = go;
    res_valid_o       = 1'b0;
    res_o.status      = STAT_OK;
    res_o.out_data    = '0;
    res_o.out_handle  = '0;
    res_o.out_length  = LEN_W'(len_q);

    case (state_q)
      BE_ISSUE: begin
        if (go) begin
          fix_kind_d = op_i.op;
          case (op_i.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              if (free_found) begin
                // take the slot, store the word and set its own links
                wd_we              = 1'b1;
                nx_we              = 1'b1;
                pv_we              = 1'b1;
                nx_waddr           = free_idx;
                pv_waddr           = free_idx;
                in_use_d[free_idx] = 1'b1;
                len_d              = len_q + SLOT_W'(1);
                fix_slot_d         = free_slot;
                if (op_i.op == OP_PUSH_FRONT) begin
                  nx_wdata  = head_q;
                  pv_wdata  = '0;
                  fix_nbr_d = head_q;
                  head_d    = free_slot;
                  if (head_q == '0) tail_d = free_slot;
                end else begin
                  nx_wdata  = '0;
                  pv_wdata  = tail_q;
                  fix_nbr_d = tail_q;
                  tail_d    = free_slot;
                  if (tail_q == '0) head_d = free_slot;
                end
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = STAT_FULL;
              end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_REMOVE: begin
              if (need_link) begin
                // fetch the node's links and word, free it
                rd_en                       = 1'b1;
                in_use_d[slot_idx(unl_slot)] = 1'b0;
                len_d                       = len_q - SLOT_W'(1);
                fix_slot_d                  = unl_slot;
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = (op_i.op == OP_REMOVE) ? STAT_BAD : STAT_EMPTY;
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      BE_LINK: begin
        res_valid_o      = 1'b1;
        res_o.out_handle = HANDLE_W'(fix_slot_q);
        case (fix_kind_q)
          OP_PUSH_FRONT: begin
            // old head points back to the new node
            if (fix_nbr_q != '0) begin
              pv_we    = 1'b1;
              pv_waddr = slot_idx(fix_nbr_q);
              pv_wdata = fix_slot_q;
            end
          end
          OP_PUSH_REAR: begin
            // old tail points forward to the new node
            if (fix_nbr_q != '0) begin
              nx_we    = 1'b1;
              nx_waddr = slot_idx(fix_nbr_q);
              nx_wdata = fix_slot_q;
            end
          end
          default: begin
            // bridge the neighbors around the freed node
            if (rd_prev_q == '0) begin
              head_d = rd_next_q;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = slot_idx(rd_prev_q);
              nx_wdata = rd_next_q;
            end
            if (rd_next_q == '0) begin
              tail_d = rd_prev_q;
            end else begin
              pv_we    = 1'b1;
              pv_waddr = slot_idx(rd_next_q);
              pv_wdata = rd_prev_q;
            end
            if (fix_kind_q != OP_REMOVE) begin
              res_o.out_data = WORD_W'(rd_word_q);
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BE_ISSUE;
      head_q     <= '0;
      tail_q     <= '0;
      len_q      <= '0;
      in_use_q   <= '0;
      fix_kind_q <= OP_NONE;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      len_q      <= len_d;
      in_use_q   <= in_use_d;
      fix_kind_q <= fix_kind_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fix_slot_q <= fix_slot_d;
    fix_nbr_q  <= fix_nbr_d;
  end

  // Store writes
  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
    if (wd_we) word_mem[wd_waddr] <= op_i.data;
  end

  // Store reads, registered
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_next_q <= next_mem[rd_addr];
      rd_prev_q <= prev_mem[rd_addr];
      rd_word_q <= word_mem[rd_addr];
    end
  end

endmodule

[rtl/core/lde_out_fifo.sv]
// Result queue between the back part and the result ports.
// Depends on lde_pkg.
`timescale 1ns / 1ps

module lde_out_fifo import lde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  out_item_t wr_item_i,
  output logic      space_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t rd_item_o
);

  out_item_t           oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                wr_en, rd_en;

  assign space_o   = (cnt_q != OQ_CNT_W'(OQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = oq_mem[rd_ptr_q];
  assign wr_en     = wr_valid_i && space_o;
  assign rd_en     = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (32'(wr_ptr_q) == OQ_DEPTH - 1) ? '0 : wr_ptr_q + OQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (32'(rd_ptr_q) == OQ_DEPTH - 1) ? '0 : rd_ptr_q + OQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + OQ_CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      oq_mem[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for linked_deque_engine_core: directed and random deque commands.
// Depends on lde_pkg and the RTL of linked_deque_engine_core; a local model predicts each result.
`timescale 1ns / 1ps

module tb_top;
  import lde_pkg::*;

  localparam int unsigned       HALF_PERIOD   = 4;
  localparam int unsigned       RESET_CYCLES  = 7;
  localparam int unsigned       CYCLE_LIMIT   = 200000;
  localparam int unsigned       SETTLE_CYCLES = 20;
  localparam int unsigned       RANDOM_ITEMS  = 700;
  localparam int unsigned       QUIET_TAIL    = 100;
  localparam logic [CMD_W-1:0]  CMD_FIRST_SPARE = 3'd5;
  localparam logic [HANDLE_W-1:0] HANDLE_MAX  = '1;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t res_o;

  linked_deque_engine_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Shadow copy of the deque: links, words, slot usage and length
  logic [SLOT_W-1:0] lnk_next [0:NODE_COUNT] = '{default: '0};
  logic [SLOT_W-1:0] lnk_prev [0:NODE_COUNT] = '{default: '0};
  logic [WORD_W-1:0] slot_word [0:NODE_COUNT] = '{default: '0};
  logic              slot_busy [0:NODE_COUNT] = '{default: 1'b0};
  int unsigned       node_total = 0;

  out_item_t   pending_results [$];
  out_item_t   want_res;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_checked   = 0;
  int unsigned status_hits [4] = '{default: 0};
  bit          send_gaps   = 1'b1;
  bit          recv_gaps   = 1'b1;
  int          stall_left  = 0;

  // Unlink one slot from the shadow list and return it to the free pool
  function automatic void unlink_node(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    p = lnk_prev[s];
    n = lnk_next[s];
    lnk_next[p] = n;
    lnk_prev[n] = p;
    lnk_next[s] = '0;
    lnk_prev[s] = '0;
    slot_busy[s] = 1'b0;
    node_total--;
  endfunction

  // Apply one command to the shadow deque and return the result it yields
  function automatic out_item_t deque_step(in_item_t it);
    out_item_t         r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    int                k;
    r = '0;
    r.status = STAT_OK;
    case (it.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        s = '0;
        for (k = NODE_COUNT; k >= 1; k--) if (!slot_busy[k]) s = SLOT_W'(k);
        if (s == '0) begin
          r.status = STAT_FULL;
        end else begin
          slot_word[s] = it.item_data;
          slot_busy[s] = 1'b1;
          if (it.cmd == CMD_PUSH_FRONT) begin
            n = lnk_next[0];
            lnk_next[s] = n;
            lnk_prev[n] = s;
            lnk_next[0] = s;
            lnk_prev[s] = '0;
          end else begin
            p = lnk_prev[0];
            lnk_next[p] = s;
            lnk_prev[s] = p;
            lnk_prev[0] = s;
            lnk_next[s] = '0;
          end
          node_total++;
          r.out_handle = s;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (node_total == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          s = (it.cmd == CMD_POP_FRONT) ? lnk_next[0] : lnk_prev[0];
          r.out_data = slot_word[s];
          unlink_node(s);
          r.out_handle = s;
        end
      end
      CMD_REMOVE: begin
        if (it.node_handle == '0 || it.node_handle > NODE_COUNT) begin
          r.status = STAT_BAD;
        end else if (!slot_busy[it.node_handle]) begin
          r.status = STAT_BAD;
        end else begin
          unlink_node(it.node_handle);
          r.out_handle = it.node_handle;
        end
      end
      default: ;
    endcase
    r.out_length = LEN_W'(node_total);
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [CMD_W-1:0] c, logic [WORD_W-1:0] d,
                                        logic [HANDLE_W-1:0] h);
    in_item_t it;
    it.cmd         = c;
    it.item_data   = d;
    it.node_handle = h;
    return it;
  endfunction

  // Offer one beat, hold it until accepted, then record its expected result
  task automatic send_cmd(in_item_t it);
    out_item_t r;
    @(negedge clk_i);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    r = deque_step(it);
    pending_results.push_back(r);
    status_hits[r.status]++;
    n_accepted++;
  endtask

  // Drop push and wait until every expected beat has come back
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: pop with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", res_o);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        n_checked++;
        if (res_o.status !== want_res.status) begin
          $error("status: expected %0d, actual %0d", want_res.status, res_o.status);
          errors++;
        end
        if (res_o.out_data !== want_res.out_data) begin
          $error("out_data: expected %h, actual %h", want_res.out_data, res_o.out_data);
          errors++;
        end
        if (res_o.out_handle !== want_res.out_handle) begin
          $error("out_handle: expected %0d, actual %0d", want_res.out_handle,
                 res_o.out_handle);
          errors++;
        end
        if (res_o.out_length !== want_res.out_length) begin
          $error("out_length: expected %0d, actual %0d", want_res.out_length,
                 res_o.out_length);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Both ends of the deque, data extremes, pops and removes on an empty list
  task automatic test_ends_and_empty();
    send_cmd(make_cmd(CMD_POP_FRONT, '0, '0));
    send_cmd(make_cmd(CMD_POP_REAR, '0, '0));
    send_cmd(make_cmd(CMD_REMOVE, '0, 5'd1));
    send_cmd(make_cmd(CMD_PUSH_FRONT, '0, '0));
    send_cmd(make_cmd(CMD_PUSH_REAR, '1, HANDLE_MAX));
    send_cmd(make_cmd(CMD_PUSH_FRONT, 32'h5A5A_A5A5, '0));
    send_cmd(make_cmd(CMD_POP_REAR, '0, '0));
    send_cmd(make_cmd(CMD_POP_FRONT, '0, '0));
    send_cmd(make_cmd(CMD_POP_FRONT, '0, '0));
    send_cmd(make_cmd(CMD_POP_REAR, '0, '0));
  endtask

  // Fill the store, overflow it, then bad handles, a real remove and spare commands
  task automatic test_full_and_handles();
    int k;
    for (k = 0; k < NODE_COUNT; k++)
      send_cmd(make_cmd((k % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom, '0));
    send_cmd(make_cmd(CMD_PUSH_REAR, '1, '0));
    send_cmd(make_cmd(CMD_REMOVE, '0, '0));
    send_cmd(make_cmd(CMD_REMOVE, '0, 5'(NODE_COUNT + 1)));
    send_cmd(make_cmd(CMD_REMOVE, '0, HANDLE_MAX));
    send_cmd(make_cmd(CMD_REMOVE, '0, 5'd7));
    send_cmd(make_cmd(CMD_REMOVE, '0, 5'd7));
    for (k = 0; k < 3; k++)
      send_cmd(make_cmd(CMD_FIRST_SPARE + CMD_W'(k), '1, HANDLE_MAX));
  endtask

  // Random traffic in fill, drain and balanced phases; quiet tail with no gaps
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned mode;
    int unsigned pick;
    int unsigned push_pct [3] = '{75, 20, 40};
    int unsigned pop_pct  [3] = '{15, 55, 35};
    int          k;
    int          start;
    in_item_t    it;
    bit          counted;
    sent = 0;
    mode = 2;
    while (sent < n_items) begin
      if (sent % 40 == 0) mode = $urandom_range(0, 2);
      if (sent == n_items / 2) drain_results();
      if (n_items - sent <= QUIET_TAIL) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      it      = make_cmd(CMD_PUSH_FRONT, $urandom, HANDLE_W'($urandom_range(0, 31)));
      counted = 1'b1;
      pick    = $urandom_range(0, 99);
      if (pick < 3) begin
        // spare codes leave the list as it is and yield an OK result
        it.cmd  = CMD_FIRST_SPARE + CMD_W'($urandom_range(0, 2));
        counted = 1'b0;
      end else if (pick < 3 + push_pct[mode]) begin
        it.cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else if (pick < 3 + push_pct[mode] + pop_pct[mode]) begin
        it.cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
      end else begin
        it.cmd = CMD_REMOVE;
        // mostly target a live node, otherwise keep the random handle
        if (node_total != 0 && $urandom_range(0, 4) != 0) begin
          start = $urandom_range(1, NODE_COUNT);
          for (k = 0; k < NODE_COUNT; k++)
            if (slot_busy[(start + k - 1) % NODE_COUNT + 1] &&
                it.node_handle != HANDLE_W'((start + k - 1) % NODE_COUNT + 1) &&
                !(it.node_handle inside {[1:NODE_COUNT]} && slot_busy[it.node_handle]))
              it.node_handle = HANDLE_W'((start + k - 1) % NODE_COUNT + 1);
        end
      end
      send_cmd(it);
      if (counted) sent++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ends_and_empty();
    drain_results();
    test_full_and_handles();
    drain_results();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d results: push/pop at both ends, removes,",
             n_accepted, n_checked);
    $display("  %0d full, %0d empty, %0d bad-handle cases, with random gaps on both sides",
             status_hits[STAT_FULL], status_hits[STAT_EMPTY], status_hits[STAT_BAD]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
